// ----- src/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types for the rgb sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	// line store depth and derived widths
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int FW_W      = 12;
	localparam int FH_W      = 13;
	localparam int ROW_W     = FH_W + 1;
	localparam int PIX_W     = 24;
	localparam int CH_W      = 8;
	localparam int SUM_W     = 21;

	// reset values of the frame registers
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

	// largest sum of squares whose rounded root still fits in eight bits
	localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(255 * 255 + 255);

	// register indexes of the configuration port
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

	// item sequencer
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WIN  = 6'b000010,
		S_GRAD = 6'b000100,
		S_SQR  = 6'b001000,
		S_SRCH = 6'b010000,
		S_PUT  = 6'b100000
	} state_t;

	typedef logic [CH_W-1:0] chan_t;

endpackage

// ----- src/sobel_edge_magnitude_rgb_top.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// Sobel 3x3 edge magnitude per color channel on a raster rgb pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction each; a flush transaction
// (cmd = 1) acts as a black pixel and drains the last row. The edge value for
// a pixel leaves when the pixel frame_width+1 places later has been taken, and
// a frame of H rows needs H*W+W+1 input transactions. Both line stores share a
// single 48-bit synchronous memory of MAX_WIDTH entries, read once and written
// once per pixel. A pixel that yields no result returns to idle after the
// write-back to the line memory; one that yields a result passes through the
// read-modify-write of the line memory, a gradient stage, a squaring stage,
// an 8-step binary search per channel for the rounded square root, with no
// steps when all three channels saturate, and then waits while the output
// register stays blocked. The output register lets the next pixel enter
// while a result waits. A write to either register restarts the frame. No
// clearing pass follows reset: cells outside the frame are masked.
module sobel_edge_magnitude_rgb_top
	import sem_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// pixel input
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic        cmd,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	// edge output
	output logic        edge_valid,
	input  logic        edge_stall,
	output logic [7:0]  red_edge,
	output logic [7:0]  green_edge,
	output logic [7:0]  blue_edge,
	output logic        frame_end,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	state_t state_q;

	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [FH_W-1:0]  out_row_q;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [PIX_W-1:0]   pix_q;
	logic [COL_W-1:0]   col_q;
	logic               produce_q;
	logic               last_q;

	logic [PIX_W-1:0] win_q [3][3];

	logic signed [10:0] gx_q [3];
	logic signed [10:0] gy_q [3];
	logic [SUM_W-1:0]   s_q  [3];
	chan_t              lo_q [3];
	chan_t              hi_q [3];

	logic [7:0] red_q, green_q, blue_q;
	logic       end_q;
	logic       out_valid_q;

	logic [FW_W-1:0]  w;
	logic [FH_W-1:0]  h;
	logic [COL_W-1:0] col;
	logic             accept;
	logic             cfg_wr;
	logic             out_free;
	logic             srch_done;

	// effective frame size
	always_comb begin
		if (frame_width_q == '0) begin
			w = FW_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			w = FW_W'(MAX_WIDTH);
		end else begin
			w = frame_width_q;
		end
		h = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	end

	assign col = ({1'b0, in_col_q} < w) ? in_col_q : COL_W'(w - FW_W'(1));

	assign pix_stall  = (state_q != S_IDLE);
	assign accept     = pix_valid && !pix_stall;
	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign out_free   = !out_valid_q || !edge_stall;

	assign edge_valid = out_valid_q;
	assign red_edge   = red_q;
	assign green_edge = green_q;
	assign blue_edge  = blue_q;
	assign frame_end  = end_q;

	// line memory: upper row in the high half, lower row in the low half
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[col];
		end
		if (state_q == S_WIN) begin
			line_mem[col_q] <= {rd_q[PIX_W-1:0], pix_q};
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q     <= col;
			pix_q     <= (!cmd && in_row_q < {1'b0, h}) ? {red_in, green_in, blue_in} : '0;
			produce_q <= (in_row_q >= ROW_W'(2)) ||
			             (in_row_q == ROW_W'(1) && col != '0);
			last_q    <= (out_row_q == h - FH_W'(1)) &&
			             ({1'b0, out_col_q} == w - FW_W'(1));
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (state_q == S_WIN) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_q[2*PIX_W-1:PIX_W];
			win_q[1][2] <= rd_q[PIX_W-1:0];
			win_q[2][2] <= pix_q;
		end
	end

	// gradients with out-of-frame cells masked
	always_ff @(posedge clk) begin
		logic       top_ok, bot_ok, lft_ok, rgt_ok;
		logic [7:0] v [3][3];
		logic [9:0] xp, xn, yp, yn;
		top_ok = (out_row_q != '0);
		bot_ok = (out_row_q != h - FH_W'(1));
		lft_ok = (out_col_q != '0);
		rgt_ok = ({1'b0, out_col_q} != w - FW_W'(1));
		if (state_q == S_GRAD) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						v[r][c] = win_q[r][c][PIX_W-1-CH_W*ch -: CH_W];
						if ((r == 0 && !top_ok) || (r == 2 && !bot_ok) ||
						    (c == 0 && !lft_ok) || (c == 2 && !rgt_ok)) begin
							v[r][c] = '0;
						end
					end
				end
				xp = {2'b0, v[0][2]} + {1'b0, v[1][2], 1'b0} + {2'b0, v[2][2]};
				xn = {2'b0, v[0][0]} + {1'b0, v[1][0], 1'b0} + {2'b0, v[2][0]};
				yp = {2'b0, v[2][0]} + {1'b0, v[2][1], 1'b0} + {2'b0, v[2][2]};
				yn = {2'b0, v[0][0]} + {1'b0, v[0][1], 1'b0} + {2'b0, v[0][2]};
				gx_q[ch] <= $signed({1'b0, xp}) - $signed({1'b0, xn});
				gy_q[ch] <= $signed({1'b0, yp}) - $signed({1'b0, yn});
			end
		end
	end

	// squares, then rounded root by binary search over k*k+k
	always_ff @(posedge clk) begin
		logic signed [21:0] sx, sy;
		logic [21:0]        sum;
		chan_t              mid;
		logic [16:0]        lim;
		for (int ch = 0; ch < 3; ch++) begin
			sx  = gx_q[ch] * gx_q[ch];
			sy  = gy_q[ch] * gy_q[ch];
			sum = $unsigned(sx) + $unsigned(sy);
			mid = chan_t'(({1'b0, lo_q[ch]} + {1'b0, hi_q[ch]}) >> 1);
			lim = ({9'b0, mid} * {9'b0, mid}) + {9'b0, mid};
			if (state_q == S_SQR) begin
				s_q[ch] <= sum[SUM_W-1:0];
				if (sum[SUM_W-1:0] > SAT_LIMIT) begin
					lo_q[ch] <= 8'd255;
				end else begin
					lo_q[ch] <= '0;
				end
				hi_q[ch] <= 8'd255;
			end else if (state_q == S_SRCH && lo_q[ch] < hi_q[ch]) begin
				if (s_q[ch] <= {4'b0, lim}) begin
					hi_q[ch] <= mid;
				end else begin
					lo_q[ch] <= mid + 8'd1;
				end
			end
		end
	end

	assign srch_done = (lo_q[0] == hi_q[0]) && (lo_q[1] == hi_q[1]) &&
	                   (lo_q[2] == hi_q[2]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!edge_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUT && out_free) begin
			red_q   <= lo_q[0];
			green_q <= lo_q[1];
			blue_q  <= lo_q[2];
			end_q   <= last_q;
		end
	end

	// sequencer, registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		logic [FW_W-1:0] nxt;
		if (!arst_n) begin
			state_q        <= S_IDLE;
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			in_col_q       <= '0;
			in_row_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (!(produce_q && last_q)) begin
						nxt = {1'b0, col_q} + FW_W'(1);
						if (nxt >= w) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + ROW_W'(1);
						end else begin
							in_col_q <= nxt[COL_W-1:0];
						end
					end
					state_q <= produce_q ? S_GRAD : S_IDLE;
				end
				S_GRAD: begin
					state_q <= S_SQR;
				end
				S_SQR: begin
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (srch_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (last_q) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
						end else begin
							nxt = {1'b0, out_col_q} + FW_W'(1);
							if (nxt >= w) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + FH_W'(1);
							end else begin
								out_col_q <= nxt[COL_W-1:0];
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end else begin
					frame_height_q <= cfg_data;
				end
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end
	end

	// an accepted pixel always goes to the memory write-back step
	a_accept_win: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_WIN)
		else $error("accepted pixel did not reach window update");

	// search interval never inverts
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH |-> lo_q[0] <= hi_q[0] && lo_q[1] <= hi_q[1] &&
		lo_q[2] <= hi_q[2])
		else $error("root search interval inverted");

	// a finished result is loaded and the sequencer returns to idle
	a_put_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUT && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("result not loaded into output register");

	// the last result of a frame restarts all positions
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUT && out_free && last_q |=>
		out_col_q == '0 && out_row_q == '0 && in_col_q == '0 && in_row_q == '0)
		else $error("counters not cleared after frame end");

endmodule
